// ===== hdl/particle_streak_integrator_defines.svh =====
// Assertion macros shared by the particle streak integrator RTL.
`ifndef PARTICLE_STREAK_INTEGRATOR_DEFINES_SVH
`define PARTICLE_STREAK_INTEGRATOR_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define PSI_ASSERT_HOLDS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// Implication checked in the same cycle.
`define PSI_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Implication whose consequent is checked in the following cycle.
`define PSI_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/psi_pkg.sv =====
// Shared types, constants and coefficient tables of the particle streak integrator.
`default_nettype none

package psi_pkg;

    localparam int FRAC_BITS = 16;
    localparam int CONST_W   = 18;
    localparam int TOTAL_W   = 17;
    localparam int TYPE_W    = 2;
    localparam int CFG_IDX_W = 3;

    // Decoupling queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef logic [CONST_W-1:0] coef_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TYPE   = 3'd0,
        CFG_FADE   = 3'd1,
        CFG_WIND_X = 3'd2,
        CFG_WIND_Y = 3'd3,
        CFG_WIND_Z = 3'd4
    } cfg_idx_t;

    typedef enum logic [TYPE_W-1:0] {
        PTYPE_0    = 2'd0,
        PTYPE_1    = 2'd1,
        PTYPE_2    = 2'd2,
        PTYPE_3UP  = 2'd3
    } ptype_t;

    // Queue status seen by the producer and the consumer
    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    // Streak length, unsigned Q2.16
    function automatic coef_t streak_coef(input logic [TYPE_W-1:0] t);
        unique case (ptype_t'(t))
            PTYPE_0:   return coef_t'(98304);
            PTYPE_1:   return coef_t'(98304);
            PTYPE_2:   return coef_t'(196608);
            PTYPE_3UP: return coef_t'(52429);
        endcase
    endfunction

    // Gravity subtracted from y velocity, unsigned Q2.16
    function automatic coef_t gravity_coef(input logic [TYPE_W-1:0] t);
        unique case (ptype_t'(t))
            PTYPE_0:   return coef_t'(1966);
            PTYPE_1:   return coef_t'(3277);
            PTYPE_2:   return coef_t'(1966);
            PTYPE_3UP: return coef_t'(262);
        endcase
    endfunction

    // Drag factor, unsigned Q2.16
    function automatic coef_t drag_coef(input logic [TYPE_W-1:0] t);
        unique case (ptype_t'(t))
            PTYPE_0:   return coef_t'(62915);
            PTYPE_1:   return coef_t'(62915);
            PTYPE_2:   return coef_t'(62915);
            PTYPE_3UP: return coef_t'(64553);
        endcase
    endfunction

endpackage

`default_nettype wire

// ===== hdl/psi_front.sv =====
// Front stage: accepts a particle and forms the partial products of the fade test.
`default_nettype none

module psi_front import psi_pkg::*; #(
    parameter int DW = 32
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [10*DW-1:0]     in_data,
    input  wire logic                 in_last,
    input  wire logic [DW-1:0]        fade_rate,
    output logic                      push,
    output logic [9*DW+8*((DW+1)/2)+1:0] push_data,
    input  wire qstat_t               qstat
);

    localparam int HW     = (DW + 1) / 2;
    localparam int PPW    = 2 * HW;
    localparam int ITEM_W = 9 * DW + 4 * PPW + 2;

    logic [DW-1:0]     age;
    logic [DW-1:0]     fade_mag;
    logic [DW-1:0]     age_mag;
    logic [PPW-1:0]    mag_f;
    logic [PPW-1:0]    mag_a;
    logic [PPW-1:0]    pp_ll;
    logic [PPW-1:0]    pp_lh;
    logic [PPW-1:0]    pp_hl;
    logic [PPW-1:0]    pp_hh;
    logic              same_sign;
    logic              accept;
    logic              valid_reg;
    logic              valid_next;
    logic [ITEM_W-1:0] item_reg;
    logic [ITEM_W-1:0] item_next;

    assign age = in_data[10*DW-1:9*DW];

    // Magnitudes of fade rate and age, split into halves
    assign fade_mag = fade_rate[DW-1] ? (~fade_rate + DW'(1)) : fade_rate;
    assign age_mag  = age[DW-1] ? (~age + DW'(1)) : age;
    assign mag_f    = PPW'(fade_mag);
    assign mag_a    = PPW'(age_mag);

    assign pp_ll = mag_f[HW-1:0]   * mag_a[HW-1:0];
    assign pp_lh = mag_f[HW-1:0]   * mag_a[PPW-1:HW];
    assign pp_hl = mag_f[PPW-1:HW] * mag_a[HW-1:0];
    assign pp_hh = mag_f[PPW-1:HW] * mag_a[PPW-1:HW];

    // Product can only exceed one when both are nonzero and share a sign
    assign same_sign = (fade_rate != '0) && (age != '0) && (fade_rate[DW-1] == age[DW-1]);

    assign item_next = {in_last, same_sign, pp_hh, pp_hl, pp_lh, pp_ll, in_data[9*DW-1:0]};

    // Hold one request; hand it on when the queue has room
    assign push       = valid_reg && !qstat.full;
    assign in_ready   = !valid_reg || !qstat.full;
    assign accept     = in_valid && in_ready;
    assign valid_next = accept || (valid_reg && qstat.full);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= item_next;
        end
    end

    assign push_data = item_reg;

endmodule

`default_nettype wire

// ===== hdl/psi_queue.sv =====
// Two-entry queue that decouples the front stage from the integration back end.
`default_nettype none
`include "particle_streak_integrator_defines.svh"

module psi_queue import psi_pkg::*; #(
    parameter int W = 8
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         push,
    input  wire logic [W-1:0] push_data,
    input  wire logic         pop,
    output logic [W-1:0]      pop_data,
    output qstat_t            qstat
);

    logic [W-1:0]      entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    // Advance pointers with wrap
    assign wr_ptr_next = !push ? wr_ptr_reg :
                         (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = !pop ? rd_ptr_reg :
                         (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming request
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data    = entry_reg[rd_ptr_reg];
    assign qstat.full  = (count_reg == QCNT_W'(QDEPTH));
    assign qstat.empty = (count_reg == '0);

    `PSI_ASSERT_SAME(a_no_push_full, aclk, aresetn, push, !qstat.full, "push into full queue")
    `PSI_ASSERT_SAME(a_no_pop_empty, aclk, aresetn, pop, !qstat.empty, "pop from empty queue")
    `PSI_ASSERT_NEXT(a_count_up, aclk, aresetn, push && !pop, count_reg == $past(count_reg) + 1'b1, "queue count did not grow on push")

endmodule

`default_nettype wire

// ===== hdl/psi_back.sv =====
// Back end: fade decision, Euler update with streak, gravity, drag and wind, live count.
`default_nettype none
`include "particle_streak_integrator_defines.svh"

module psi_back import psi_pkg::*; #(
    parameter int DW   = 32,
    parameter int MAXP = 65536
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    output logic                           pop,
    input  wire logic [9*DW+8*((DW+1)/2)+1:0] q_data,
    input  wire qstat_t                    qstat,
    input  wire logic [TYPE_W-1:0]         ptype,
    input  wire logic signed [DW-1:0]      wind_x,
    input  wire logic signed [DW-1:0]      wind_y,
    input  wire logic signed [DW-1:0]      wind_z,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic [9*DW-1:0]                out_data,
    output logic                           out_alive,
    output logic [TOTAL_W-1:0]             out_total,
    output logic                           out_last
);

    localparam int HW      = (DW + 1) / 2;
    localparam int PPW     = 2 * HW;
    localparam int PROD_W  = 2 * PPW;
    localparam int CMP_W   = (PROD_W > 2 * FRAC_BITS + 1) ? PROD_W : 2 * FRAC_BITS + 1;
    localparam int OFS_PP  = 9 * DW;
    localparam int OFS_FLG = 9 * DW + 4 * PPW;
    localparam int SPW     = DW + CONST_W + 1;
    localparam int DPW     = DW + CONST_W + 2;
    localparam int CW      = $clog2(MAXP + 1);

    localparam logic [CMP_W-1:0]        ONE_SQ  = CMP_W'(1) << (2 * FRAC_BITS);
    localparam logic signed [DPW-1:0]   SAT_MAX = {{(DPW-DW+1){1'b0}}, {(DW-1){1'b1}}};
    localparam logic signed [DPW-1:0]   SAT_MIN = ~SAT_MAX;
    localparam logic signed [DPW-1:0]   RND     = DPW'(1) << (FRAC_BITS - 1);

    function automatic logic [DW-1:0] sat_dw(input logic signed [DPW-1:0] v);
        if (v > SAT_MAX) begin
            return SAT_MAX[DW-1:0];
        end else if (v < SAT_MIN) begin
            return SAT_MIN[DW-1:0];
        end else begin
            return v[DW-1:0];
        end
    endfunction

    logic [PPW-1:0]    pp_ll;
    logic [PPW-1:0]    pp_lh;
    logic [PPW-1:0]    pp_hl;
    logic [PPW-1:0]    pp_hh;
    logic [PROD_W-1:0] prod;
    logic              alive_w;
    coef_t             streak;
    coef_t             gravity;
    coef_t             drag;

    logic              move1;
    logic              move2;
    logic              load2;
    logic              v1_reg;
    logic              v1_next;
    logic              v2_reg;
    logic              v2_next;
    logic              alive1_reg;
    logic              last1_reg;
    logic              alive2_reg;
    logic              last2_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic [TOTAL_W-1:0] total_next;
    logic [CW-1:0]     cnt_reg;
    logic [CW-1:0]     cnt_next;
    logic [CW-1:0]     cnt_inc;

    assign streak  = streak_coef(ptype);
    assign gravity = gravity_coef(ptype);
    assign drag    = drag_coef(ptype);

    // Sum the partial products and test against one
    assign pp_ll = q_data[OFS_PP +: PPW];
    assign pp_lh = q_data[OFS_PP + PPW +: PPW];
    assign pp_hl = q_data[OFS_PP + 2*PPW +: PPW];
    assign pp_hh = q_data[OFS_PP + 3*PPW +: PPW];
    assign prod  = (PROD_W'(pp_hh) << PPW)
                 + ((PROD_W'(pp_lh) + PROD_W'(pp_hl)) << HW)
                 + PROD_W'(pp_ll);
    assign alive_w = !(q_data[OFS_FLG] && (CMP_W'(prod) > ONE_SQ));

    // Two-stage pipeline with the output register as the last stage
    assign move2   = !v2_reg || m_ready;
    assign load2   = v1_reg && move2;
    assign move1   = !v1_reg || move2;
    assign pop     = !qstat.empty && move1;
    assign v1_next = pop || (v1_reg && !move2);
    assign v2_next = load2 || (v2_reg && !m_ready);

    // Count live particles, saturate, report and clear on the last one
    assign cnt_inc    = (alive1_reg && (cnt_reg < CW'(MAXP))) ? cnt_reg + 1'b1 : cnt_reg;
    assign cnt_next   = load2 ? (last1_reg ? '0 : cnt_inc) : cnt_reg;
    assign total_next = last1_reg ? TOTAL_W'(cnt_inc) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            cnt_reg <= '0;
        end else begin
            v1_reg  <= v1_next;
            v2_reg  <= v2_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            alive1_reg <= alive_w;
            last1_reg  <= q_data[OFS_FLG + 1];
        end
        if (load2) begin
            alive2_reg <= alive1_reg;
            last2_reg  <= last1_reg;
            total_reg  <= total_next;
        end
    end

    // Per-axis datapath lanes
    for (genvar a = 0; a < 3; a++) begin : g_axis
        logic signed [DW-1:0]   head_w;
        logic signed [DW-1:0]   tail_w;
        logic signed [DW-1:0]   vel_w;
        logic signed [DW-1:0]   wind_w;
        coef_t                  grav_w;
        logic signed [DW:0]     hsum;
        logic signed [DW:0]     vadj;
        logic signed [SPW-1:0]  sp_w;
        logic signed [DPW-1:0]  dp_w;
        logic signed [DW-1:0]   nh1_reg;
        logic signed [DW-1:0]   tail1_reg;
        logic signed [DW-1:0]   vel1_reg;
        logic signed [SPW-1:0]  sp1_reg;
        logic signed [DPW-1:0]  dp1_reg;
        logic signed [DPW-1:0]  ms;
        logic signed [DPW-1:0]  md;
        logic signed [DPW-1:0]  nt_w;
        logic signed [DPW-1:0]  nv_w;
        logic [DW-1:0]          oh_reg;
        logic [DW-1:0]          ot_reg;
        logic [DW-1:0]          ov_reg;

        assign head_w = q_data[a*DW +: DW];
        assign tail_w = q_data[(3+a)*DW +: DW];
        assign vel_w  = q_data[(6+a)*DW +: DW];
        assign wind_w = (a == 0) ? wind_x : ((a == 1) ? wind_y : wind_z);
        assign grav_w = (a == 1) ? gravity : '0;

        // Head step, streak and drag products
        assign hsum = (DW+1)'(head_w) + (DW+1)'(vel_w);
        assign vadj = (DW+1)'(vel_w) - (DW+1)'($signed({1'b0, grav_w}));
        assign sp_w = vel_w * $signed({1'b0, streak});
        assign dp_w = vadj * $signed({1'b0, drag});

        always_ff @(posedge aclk) begin
            if (pop) begin
                nh1_reg   <= sat_dw(DPW'(hsum));
                tail1_reg <= tail_w;
                vel1_reg  <= vel_w;
                sp1_reg   <= sp_w;
                dp1_reg   <= dp_w;
            end
        end

        // Round products, form tail and velocity, saturate
        assign ms   = (DPW'(sp1_reg) + RND) >>> FRAC_BITS;
        assign md   = (dp1_reg + RND) >>> FRAC_BITS;
        assign nt_w = DPW'(nh1_reg) - ms;
        assign nv_w = md + DPW'(wind_w);

        always_ff @(posedge aclk) begin
            if (load2) begin
                if (alive1_reg) begin
                    oh_reg <= nh1_reg;
                    ot_reg <= sat_dw(nt_w);
                    ov_reg <= sat_dw(nv_w);
                end else begin
                    oh_reg <= tail1_reg;
                    ot_reg <= tail1_reg;
                    ov_reg <= vel1_reg;
                end
            end
        end

        assign out_data[a*DW +: DW]     = oh_reg;
        assign out_data[(3+a)*DW +: DW] = ot_reg;
        assign out_data[(6+a)*DW +: DW] = ov_reg;
    end

    assign m_valid   = v2_reg;
    assign out_alive = alive2_reg;
    assign out_total = total_reg;
    assign out_last  = last2_reg;

    `PSI_ASSERT_HOLDS(a_cnt_bound, aclk, aresetn, cnt_reg <= CW'(MAXP), "live count above limit")
    `PSI_ASSERT_NEXT(a_cnt_clear, aclk, aresetn, load2 && last1_reg, cnt_reg == '0, "live count not cleared after last")
    `PSI_ASSERT_SAME(a_dead_collapse, aclk, aresetn, v2_reg && !alive2_reg, out_data[3*DW-1:0] == out_data[6*DW-1:3*DW], "dead particle head differs from tail")

endmodule

`default_nettype wire

// ===== hdl/particle_streak_integrator.sv =====
// Particle streak integrator top level: config registers, front, queue and back end.
// One particle enters per request on the s_ stream: head, tail and velocity (x, y, z)
// and age, all signed Q16.16, with s_tlast marking the final particle of a batch.
// Each request yields one result on the m_ stream: new head, tail and velocity,
// m_tuser set when the particle was live, and on the m_tlast result the count of
// live particles in the batch, after which the count starts again from zero.
// Configuration (type, fade rate, wind) is written through cfg_wr_* while idle; the
// user must ensure this, as the block does not enforce it. A particle passes the front
// register, queue entry, product stage and output register. Throughput: one particle
// per cycle when unstalled; all multipliers are pipelined so nothing iterates.
// When m_tready is low the output register holds its result, the back end stalls,
// the two-entry queue fills and s_tready falls once the front register is also
// occupied; no request is lost or repeated. A synchronous low aresetn empties all
// stages and the queue, clears the live count and sets every configuration
// register to zero.

`default_nettype none

module particle_streak_integrator import psi_pkg::*; #(
    parameter int MAX_PARTICLES = 65536,
    parameter int DATA_WIDTH    = 32,
    localparam int S_TDATA_W    = ((10 * DATA_WIDTH + 7) / 8) * 8,
    localparam int M_TDATA_W    = ((9 * DATA_WIDTH + TOTAL_W + 7) / 8) * 8
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // head_x, head_y, head_z, tail_x, tail_y, tail_z, vel_x, vel_y, vel_z, age
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    input  wire logic                  s_tlast,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // new_head_x..z, new_tail_x..z, new_vel_x..z, alive_total
    output logic [M_TDATA_W-1:0]       m_tdata,
    // is_alive
    output logic                       m_tuser,
    output logic                       m_tlast,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  wire logic [DATA_WIDTH-1:0] cfg_wr_data
);

    localparam int DW     = DATA_WIDTH;
    localparam int ITEM_W = 9 * DW + 8 * ((DW + 1) / 2) + 2;

    logic [TYPE_W-1:0] ptype_reg;
    logic [DW-1:0]     fade_reg;
    logic [DW-1:0]     wind_x_reg;
    logic [DW-1:0]     wind_y_reg;
    logic [DW-1:0]     wind_z_reg;

    logic              push;
    logic              pop;
    logic [ITEM_W-1:0] push_data;
    logic [ITEM_W-1:0] pop_data;
    qstat_t            qstat;
    logic [9*DW-1:0]   out_data;
    logic [TOTAL_W-1:0] out_total;

    // Decode configuration writes; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptype_reg  <= '0;
            fade_reg   <= '0;
            wind_x_reg <= '0;
            wind_y_reg <= '0;
            wind_z_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_wr_index))
                CFG_TYPE:   ptype_reg  <= cfg_wr_data[TYPE_W-1:0];
                CFG_FADE:   fade_reg   <= cfg_wr_data;
                CFG_WIND_X: wind_x_reg <= cfg_wr_data;
                CFG_WIND_Y: wind_y_reg <= cfg_wr_data;
                CFG_WIND_Z: wind_z_reg <= cfg_wr_data;
                default:    ;
            endcase
        end
    end

    psi_front #(
        .DW (DW)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata[10*DW-1:0]),
        .in_last   (s_tlast),
        .fade_rate (fade_reg),
        .push      (push),
        .push_data (push_data),
        .qstat     (qstat)
    );

    psi_queue #(
        .W (ITEM_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .qstat     (qstat)
    );

    psi_back #(
        .DW   (DW),
        .MAXP (MAX_PARTICLES)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop       (pop),
        .q_data    (pop_data),
        .qstat     (qstat),
        .ptype     (ptype_reg),
        .wind_x    (wind_x_reg),
        .wind_y    (wind_y_reg),
        .wind_z    (wind_z_reg),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .out_data  (out_data),
        .out_alive (m_tuser),
        .out_total (out_total),
        .out_last  (m_tlast)
    );

    assign m_tdata = M_TDATA_W'({out_total, out_data});

endmodule

`default_nettype wire
